// File: rtl/led_fill_wipe_blend_defines.svh
// ----------------------------------------------------------------------------
// led_fill_wipe_blend assertion macros
// Shared property wrappers for the block's checker.
// ----------------------------------------------------------------------------
`ifndef LED_FILL_WIPE_BLEND_DEFINES_SVH
`define LED_FILL_WIPE_BLEND_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define LFWB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lfwb check failed in %m");

// Next-cycle implication, disabled while reset is held
`define LFWB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lfwb check failed in %m");

`endif

// File: rtl/lfwb_pkg.sv
// ----------------------------------------------------------------------------
// lfwb_pkg
// Types, widths and register codes shared by the fill/wipe blend block.
// ----------------------------------------------------------------------------
package lfwb_pkg;

	// Field widths
	localparam int IDX_W     = 10;
	localparam int COL_W     = 8;
	localparam int TIME_W    = 16;
	localparam int CFG_W     = 16;
	localparam int LEN_W     = 11;
	localparam int POS_DEN_W = LEN_W;
	localparam int HSV_W     = 3 * COL_W;

	// Fixed-point layout
	localparam int PROD_W     = TIME_W + CFG_W;
	localparam int SPEED_FRAC = 8;
	localparam int POS_FRAC   = 16;
	localparam int LAG_W      = 27;
	localparam int SLOPE_FRAC = 8;
	localparam int MPROD_W    = LAG_W + CFG_W;
	localparam int ALPHA_W    = 17;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);
	localparam logic [CFG_W-1:0] SPEED_UNITY = CFG_W'(256);

	// Stream widths
	localparam int TDATA_IN_W  = 56;
	localparam int TDATA_OUT_W = 40;

	// Configuration port
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FILL_HUE     = 3'd0,
		CFG_FILL_SAT     = 3'd1,
		CFG_FILL_VAL     = 3'd2,
		CFG_EDGE_SLOPE   = 3'd3,
		CFG_SWEEP_SPEED  = 3'd4,
		CFG_SPAN_TICKS   = 3'd5,
		CFG_STRIP_LENGTH = 3'd6
	} cfg_reg_t;

	// Register reset values
	localparam logic [COL_W-1:0] RST_FILL        = '0;
	localparam logic [CFG_W-1:0] RST_EDGE_SLOPE  = '0;
	localparam logic [CFG_W-1:0] RST_SWEEP_SPEED = SPEED_UNITY;
	localparam logic [CFG_W-1:0] RST_SPAN_TICKS  = '0;
	localparam logic [LEN_W-1:0] RST_STRIP_LEN   = LEN_W'(2);

	localparam int DEFAULT_MAX_PIXELS = 1024;

	typedef struct packed {
		logic [COL_W-1:0] h;
		logic [COL_W-1:0] s;
		logic [COL_W-1:0] v;
	} hsv_t;

	// Item as it travels down the pipeline
	typedef struct packed {
		logic             render;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] addr;
		hsv_t             col;
	} item_t;

	// Finished result beat
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		hsv_t             col;
	} res_t;

endpackage

// File: rtl/lfwb_ram.sv
// ----------------------------------------------------------------------------
// lfwb_ram
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module lfwb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write on we, otherwise read; read data changes only on a read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: rtl/lfwb_quot_pipe.sv
// ----------------------------------------------------------------------------
// lfwb_quot_pipe
// Restoring divider pipeline, one quotient bit per stage, running the time
// lag and the strip position divisions side by side with the store address
// reduction.
// ----------------------------------------------------------------------------
module lfwb_quot_pipe #(
	parameter int MAX_PIXELS = lfwb_pkg::DEFAULT_MAX_PIXELS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  lfwb_pkg::item_t                in_item,
	input  logic [lfwb_pkg::PROD_W-1:0]    in_prod,
	input  logic [lfwb_pkg::CFG_W-1:0]     span,
	input  logic [lfwb_pkg::POS_DEN_W-1:0] pos_den,
	output logic                           out_vld,
	output lfwb_pkg::item_t                out_item,
	output logic [lfwb_pkg::LAG_W-1:0]     lag,
	output logic                           lag_sat,
	output logic [lfwb_pkg::LAG_W-1:0]     pos
);

	localparam int STEPS  = lfwb_pkg::LAG_W;
	localparam int DVD_W  = lfwb_pkg::PROD_W + lfwb_pkg::SPEED_FRAC;
	localparam int SPAN_W = lfwb_pkg::CFG_W;
	localparam int PDEN_W = lfwb_pkg::POS_DEN_W;
	localparam int IDX_W  = lfwb_pkg::IDX_W;

	logic [STEPS-1:0]  vld_q;
	lfwb_pkg::item_t   item_q [STEPS];
	logic [SPAN_W-1:0] lrem_q [STEPS];
	logic [STEPS-1:0]  ldq_q  [STEPS];
	logic [PDEN_W-1:0] prem_q [STEPS];
	logic [STEPS-1:0]  pdq_q  [STEPS];
	logic              sat_q  [STEPS];

	lfwb_pkg::item_t   n_item [STEPS];
	logic [SPAN_W-1:0] n_lrem [STEPS];
	logic [STEPS-1:0]  n_ldq  [STEPS];
	logic [PDEN_W-1:0] n_prem [STEPS];
	logic [STEPS-1:0]  n_pdq  [STEPS];
	logic              n_sat  [STEPS];

	// One compare-subtract step per stage for both quotients
	always_comb begin
		logic [DVD_W-1:0]  dvd;
		lfwb_pkg::item_t   c_item;
		logic [SPAN_W-1:0] c_lrem;
		logic [STEPS-1:0]  c_ldq;
		logic [PDEN_W-1:0] c_prem;
		logic [STEPS-1:0]  c_pdq;
		logic              c_sat;
		logic [SPAN_W:0]   lt;
		logic [PDEN_W:0]   pt;
		logic              lge;
		logic              pge;
		logic [31:0]       sub;

		dvd = {in_prod, {lfwb_pkg::SPEED_FRAC{1'b0}}};
		for (int j = 0; j < STEPS; j++) begin
			if (j == 0) begin
				// Bits above the quotient width seed the remainder
				c_item = in_item;
				c_lrem = SPAN_W'(dvd[DVD_W-1:STEPS]);
				c_ldq  = dvd[STEPS-1:0];
				c_prem = '0;
				c_pdq  = STEPS'(in_item.idx) << lfwb_pkg::POS_FRAC;
				c_sat  = SPAN_W'(dvd[DVD_W-1:STEPS]) >= span;
			end else begin
				c_item = item_q[j-1];
				c_lrem = lrem_q[j-1];
				c_ldq  = ldq_q[j-1];
				c_prem = prem_q[j-1];
				c_pdq  = pdq_q[j-1];
				c_sat  = sat_q[j-1];
			end

			lt  = {c_lrem, c_ldq[STEPS-1]};
			lge = lt >= {1'b0, span};
			n_lrem[j] = lge ? SPAN_W'(lt - {1'b0, span}) : lt[SPAN_W-1:0];
			n_ldq[j]  = {c_ldq[STEPS-2:0], lge};

			pt  = {c_prem, c_pdq[STEPS-1]};
			pge = pt >= {1'b0, pos_den};
			n_prem[j] = pge ? PDEN_W'(pt - {1'b0, pos_den}) : pt[PDEN_W-1:0];
			n_pdq[j]  = {c_pdq[STEPS-2:0], pge};

			n_sat[j]  = c_sat;
			n_item[j] = c_item;

			// Reduce the store address modulo the store depth, largest multiple first
			if (j < IDX_W) begin
				sub = 32'(MAX_PIXELS) << (IDX_W - 1 - j);
				if (32'(c_item.addr) >= sub) begin
					n_item[j].addr = IDX_W'(32'(c_item.addr) - sub);
				end
			end
		end
	end

	// Advance the valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[STEPS-2:0], in_vld};
		end
	end

	// Advance the stage payloads
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < STEPS; j++) begin
				item_q[j] <= n_item[j];
				lrem_q[j] <= n_lrem[j];
				ldq_q[j]  <= n_ldq[j];
				prem_q[j] <= n_prem[j];
				pdq_q[j]  <= n_pdq[j];
				sat_q[j]  <= n_sat[j];
			end
		end
	end

	assign out_vld  = vld_q[STEPS-1];
	assign out_item = item_q[STEPS-1];
	assign lag      = ldq_q[STEPS-1];
	assign lag_sat  = sat_q[STEPS-1];
	assign pos      = pdq_q[STEPS-1];

endmodule

// File: rtl/led_fill_wipe_blend.sv
// ----------------------------------------------------------------------------
// led_fill_wipe_blend
// Blends LED strip pixels from a captured background toward a fill colour,
// either as a uniform crossfade or as a linear wipe edge along the strip.
//
// Channel   Ports                     Beat
// input     s_axis_t{valid,ready}     tuser: action; tdata: pixel_index,
//                                     pixel_h, pixel_s, pixel_v, time_now
// output    m_axis_t{valid,ready}     tdata: out_index, out_h, out_s, out_v
// config    cfg_we, cfg_index         cfg_data written on the edge with cfg_we
//
// One beat per cycle sustained while the skid is empty. A render beat passes
// through stage 1, the 27-stage restoring divider pipeline and stages 2 to 4.
// Background store: one RAM accessed by every beat at the same pipeline
// stage, captures writing and renders reading, so no forwarding is needed.
// No clearing pass after reset: the store is valid only where captured.
// A stalled output fills a one-beat skid; s_axis_tready drops while it is full.
// ----------------------------------------------------------------------------
module led_fill_wipe_blend #(
	parameter int MAX_PIXELS = lfwb_pkg::DEFAULT_MAX_PIXELS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [lfwb_pkg::TDATA_IN_W-1:0]    s_axis_tdata,  // pixel_index, pixel_h, pixel_s,
	                                                          // pixel_v, time_now, zero pad
	input  logic [0:0]                         s_axis_tuser,  // action
	// Output stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [lfwb_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,  // out_index, out_h, out_s,
	                                                          // out_v, zero pad
	// Configuration writes
	input  logic                               cfg_we,
	input  logic [lfwb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lfwb_pkg::CFG_W-1:0]         cfg_data
);

	localparam int AW        = $clog2(MAX_PIXELS);
	localparam int IDX_W     = lfwb_pkg::IDX_W;
	localparam int COL_W     = lfwb_pkg::COL_W;
	localparam int TIME_W    = lfwb_pkg::TIME_W;
	localparam int CFG_W     = lfwb_pkg::CFG_W;
	localparam int LEN_W     = lfwb_pkg::LEN_W;
	localparam int LAG_W     = lfwb_pkg::LAG_W;
	localparam int ALPHA_W   = lfwb_pkg::ALPHA_W;
	localparam int MPROD_W   = lfwb_pkg::MPROD_W;
	localparam int PROD_W    = lfwb_pkg::PROD_W;
	localparam int FRAC      = lfwb_pkg::SLOPE_FRAC;
	localparam int H_LSB     = IDX_W;
	localparam int S_LSB     = H_LSB + COL_W;
	localparam int V_LSB     = S_LSB + COL_W;
	localparam int T_LSB     = V_LSB + COL_W;
	localparam int RES_W     = IDX_W + lfwb_pkg::HSV_W;

	// Configuration registers
	logic [COL_W-1:0] fill_hue_q;
	logic [COL_W-1:0] fill_sat_q;
	logic [COL_W-1:0] fill_val_q;
	logic [CFG_W-1:0] edge_slope_q;
	logic [CFG_W-1:0] sweep_speed_q;
	logic [CFG_W-1:0] span_ticks_q;
	logic [LEN_W-1:0] strip_length_q;

	logic                             en;
	logic [LEN_W-1:0]                 len_clamped;
	logic [lfwb_pkg::POS_DEN_W-1:0]   pos_den;
	logic [CFG_W-1:0]                 speed_sel;

	// Stage 1: inputs and the time product
	logic                  vld_s1;
	lfwb_pkg::item_t       item_s1;
	logic [PROD_W-1:0]     prod_s1;

	// Divider outputs
	logic                  dv_vld;
	lfwb_pkg::item_t       dv_item;
	logic [LAG_W-1:0]      dv_lag;
	logic                  dv_sat;
	logic [LAG_W-1:0]      dv_pos;

	// Stage 2: lag minus position
	logic                  vld_s2;
	lfwb_pkg::item_t       item_s2;
	logic                  gt_s2;
	logic                  sat_s2;
	logic [LAG_W-1:0]      diff_s2;
	logic [ALPHA_W-1:0]    acf_s2;

	// Stage 3: edge product
	logic                  vld_s3;
	lfwb_pkg::item_t       item_s3;
	logic                  gt_s3;
	logic                  sat_s3;
	logic [ALPHA_W-1:0]    acf_s3;
	logic [MPROD_W-1:0]    mprod_s3;

	// Stage 4: blend factor, background read in flight
	logic                  vld_s4;
	lfwb_pkg::item_t       item_s4;
	logic [ALPHA_W-1:0]    alpha_s4;

	logic                  ram_en;
	logic [lfwb_pkg::HSV_W-1:0] ram_rdata;
	lfwb_pkg::hsv_t        bg;

	// Output register and skid
	logic                  res_vld;
	lfwb_pkg::res_t        res;
	logic                  out_vld_q;
	lfwb_pkg::res_t        out_q;
	logic                  skid_vld_q;
	lfwb_pkg::res_t        skid_q;
	logic                  out_free;

	function automatic logic [COL_W-1:0] mix8(
		input logic [COL_W-1:0]   bgc,
		input logic [COL_W-1:0]   fgc,
		input logic [ALPHA_W-1:0] a
	);
		logic [ALPHA_W-1:0]       na;
		logic [ALPHA_W+COL_W-1:0] pb;
		logic [ALPHA_W+COL_W-1:0] pf;
		logic [ALPHA_W+COL_W-1:0] acc;
		na  = lfwb_pkg::ALPHA_ONE - a;
		pb  = (ALPHA_W+COL_W)'(na) * (ALPHA_W+COL_W)'(bgc);
		pf  = (ALPHA_W+COL_W)'(a) * (ALPHA_W+COL_W)'(fgc);
		acc = pb + pf;
		return acc[16 +: COL_W];
	endfunction

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_hue_q     <= lfwb_pkg::RST_FILL;
			fill_sat_q     <= lfwb_pkg::RST_FILL;
			fill_val_q     <= lfwb_pkg::RST_FILL;
			edge_slope_q   <= lfwb_pkg::RST_EDGE_SLOPE;
			sweep_speed_q  <= lfwb_pkg::RST_SWEEP_SPEED;
			span_ticks_q   <= lfwb_pkg::RST_SPAN_TICKS;
			strip_length_q <= lfwb_pkg::RST_STRIP_LEN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lfwb_pkg::CFG_FILL_HUE:     fill_hue_q     <= cfg_data[COL_W-1:0];
				lfwb_pkg::CFG_FILL_SAT:     fill_sat_q     <= cfg_data[COL_W-1:0];
				lfwb_pkg::CFG_FILL_VAL:     fill_val_q     <= cfg_data[COL_W-1:0];
				lfwb_pkg::CFG_EDGE_SLOPE:   edge_slope_q   <= cfg_data;
				lfwb_pkg::CFG_SWEEP_SPEED:  sweep_speed_q  <= cfg_data;
				lfwb_pkg::CFG_SPAN_TICKS:   span_ticks_q   <= cfg_data;
				lfwb_pkg::CFG_STRIP_LENGTH: strip_length_q <= cfg_data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Clamp the strip length into range and derive the position divisor
	always_comb begin
		priority if (strip_length_q < LEN_W'(2)) begin
			len_clamped = LEN_W'(2);
		end else if (32'(strip_length_q) > 32'(MAX_PIXELS)) begin
			len_clamped = LEN_W'(MAX_PIXELS);
		end else begin
			len_clamped = strip_length_q;
		end
	end
	assign pos_den = len_clamped - LEN_W'(1);

	// Crossfade runs through the lag divider at unit speed
	assign speed_sel = (edge_slope_q == '0) ? lfwb_pkg::SPEED_UNITY : sweep_speed_q;

	// The whole pipeline moves while the skid is empty
	assign en            = !skid_vld_q;
	assign s_axis_tready = en;

	// Stage 1: register the beat and form time times speed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1.render <= s_axis_tuser[0];
			item_s1.idx    <= s_axis_tdata[IDX_W-1:0];
			item_s1.addr   <= s_axis_tdata[IDX_W-1:0];
			item_s1.col.h  <= s_axis_tdata[H_LSB +: COL_W];
			item_s1.col.s  <= s_axis_tdata[S_LSB +: COL_W];
			item_s1.col.v  <= s_axis_tdata[V_LSB +: COL_W];
			prod_s1        <= PROD_W'(s_axis_tdata[T_LSB +: TIME_W]) * PROD_W'(speed_sel);
		end
	end

	lfwb_quot_pipe #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_quot_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s1),
		.in_item  (item_s1),
		.in_prod  (prod_s1),
		.span     (span_ticks_q),
		.pos_den  (pos_den),
		.out_vld  (dv_vld),
		.out_item (dv_item),
		.lag      (dv_lag),
		.lag_sat  (dv_sat),
		.pos      (dv_pos)
	);

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s2 <= dv_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Stages 2 to 4: edge distance, edge product, blend factor
	always_ff @(posedge clk) begin
		if (en) begin
			item_s2 <= dv_item;
			sat_s2  <= dv_sat;
			gt_s2   <= dv_sat || (dv_lag > dv_pos);
			diff_s2 <= dv_lag - dv_pos;
			if (dv_sat || (dv_lag > LAG_W'(lfwb_pkg::ALPHA_ONE))) begin
				acf_s2 <= lfwb_pkg::ALPHA_ONE;
			end else begin
				acf_s2 <= dv_lag[ALPHA_W-1:0];
			end

			item_s3  <= item_s2;
			sat_s3   <= sat_s2;
			gt_s3    <= gt_s2;
			acf_s3   <= acf_s2;
			mprod_s3 <= MPROD_W'(diff_s2) * MPROD_W'(edge_slope_q);

			item_s4 <= item_s3;
			priority if (span_ticks_q == '0) begin
				alpha_s4 <= lfwb_pkg::ALPHA_ONE;
			end else if (edge_slope_q == '0) begin
				alpha_s4 <= acf_s3;
			end else if (!gt_s3) begin
				alpha_s4 <= '0;
			end else if (sat_s3 || (mprod_s3[MPROD_W-1:FRAC] >
			                        (MPROD_W-FRAC)'(lfwb_pkg::ALPHA_ONE))) begin
				alpha_s4 <= lfwb_pkg::ALPHA_ONE;
			end else begin
				alpha_s4 <= mprod_s3[FRAC +: ALPHA_W];
			end
		end
	end

	// Background store: captures write, renders read, both at stage 3
	assign ram_en = en && vld_s3;

	lfwb_ram #(
		.WIDTH (lfwb_pkg::HSV_W),
		.DEPTH (MAX_PIXELS)
	) u_bg_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (!item_s3.render),
		.addr  (AW'(item_s3.addr)),
		.wdata (item_s3.col),
		.rdata (ram_rdata)
	);

	assign bg = ram_rdata;

	// Blend each channel
	assign res_vld   = en && vld_s4 && item_s4.render;
	assign res.idx   = item_s4.idx;
	assign res.col.h = mix8(bg.h, fill_hue_q, alpha_s4);
	assign res.col.s = mix8(bg.s, fill_sat_q, alpha_s4);
	assign res.col.v = mix8(bg.v, fill_val_q, alpha_s4);

	assign out_free = !out_vld_q || m_axis_tready;

	// Output register with skid: drain skid first, then park new results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			priority if (skid_vld_q) begin
				if (out_free) begin
					out_vld_q  <= 1'b1;
					skid_vld_q <= 1'b0;
				end
			end else if (res_vld) begin
				if (out_free) begin
					out_vld_q <= 1'b1;
				end else begin
					skid_vld_q <= 1'b1;
				end
			end else if (out_free) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (skid_vld_q) begin
			if (out_free) begin
				out_q <= skid_q;
			end
		end else if (res_vld) begin
			if (out_free) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {(lfwb_pkg::TDATA_OUT_W - RES_W)'(0),
	                        out_q.col.v, out_q.col.s, out_q.col.h, out_q.idx};

endmodule

// File: rtl/lfwb_checker.sv
// ----------------------------------------------------------------------------
// lfwb_checker
// Port-level checks on the blend block's output handshake and stall path.
// ----------------------------------------------------------------------------
`include "led_fill_wipe_blend_defines.svh"

module lfwb_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [lfwb_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);

	// Hold a stalled result beat
	`LFWB_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`LFWB_ASSERT_NXT(a_data_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

	// Input back-pressure only ever comes with a result waiting
	`LFWB_ASSERT_IMP(a_stall_has_result, clk, arst_n, !s_axis_tready, m_axis_tvalid)

	// The skid fills only after an output stall
	`LFWB_ASSERT_IMP(a_stall_cause, clk, arst_n, $fell(s_axis_tready), $past(m_axis_tvalid && !m_axis_tready))

endmodule

bind led_fill_wipe_blend lfwb_checker u_lfwb_checker (.*);

// File: tb/sv/led_fill_wipe_blend_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_fill_wipe_blend_tb
// Self-checking bench for the fill/wipe blend block. Background pixels are
// captured, then rendered under instant fill, uniform crossfade and wipe edge
// settings. A shadow copy of the store and registers predicts every rendered
// beat, which is compared field by field as it leaves the block. Both stream
// sides idle at random; one stretch holds the output off long enough to
// back-pressure the input.
// ----------------------------------------------------------------------------
module led_fill_wipe_blend_tb;
	import lfwb_pkg::*;

	localparam int PIXELS          = DEFAULT_MAX_PIXELS;
	localparam int SETTLE_CYCLES   = 40;
	localparam int DRAIN_CAP       = 4000;
	localparam int LONG_HOLD       = 200;
	localparam int RAND_PHASES     = 13;
	localparam int ITEMS_PER_PHASE = 90;

	typedef enum logic {
		PX_CAPTURE = 1'b0,
		PX_RENDER  = 1'b1
	} pixel_act_t;

	// One rendered pixel as it should leave the block
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		hsv_t             col;
	} blend_px_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [TDATA_IN_W-1:0]  s_axis_tdata;  // pixel_index, pixel_h, pixel_s,
	                                       // pixel_v, time_now, zero pad
	logic [0:0]             s_axis_tuser;  // action
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;  // out_index, out_h, out_s,
	                                       // out_v, zero pad
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	// Shadow registers and background store
	hsv_t             fill_sh       = '{h: RST_FILL, s: RST_FILL, v: RST_FILL};
	logic [CFG_W-1:0] edge_slope_sh = RST_EDGE_SLOPE;
	logic [CFG_W-1:0] sweep_speed_sh = RST_SWEEP_SPEED;
	logic [CFG_W-1:0] span_ticks_sh = RST_SPAN_TICKS;
	logic [LEN_W-1:0] strip_len_sh  = RST_STRIP_LEN;
	hsv_t             bg_shadow [PIXELS];
	bit               bg_written [PIXELS];
	int unsigned      captured_idx [$];

	blend_px_t blended_q [$];
	int        mismatches   = 0;
	bit        src_idle_on  = 1'b1;
	bit        sink_idle_on = 1'b1;
	int        sink_gap     = 0;
	int        sink_hold    = 0;

	led_fill_wipe_blend u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Blend one channel: Q16 weighted sum of background and fill
	function automatic logic [COL_W-1:0] mix_channel(logic [COL_W-1:0] bg,
			logic [COL_W-1:0] fg, longint unsigned alpha);
		logic [63:0] acc;
		acc = (64'd65536 - alpha) * bg + alpha * fg;
		return acc[23:16];
	endfunction

	// Work out the colour a render beat should produce
	function automatic blend_px_t blend_pixel(logic [IDX_W-1:0] idx, logic [TIME_W-1:0] t_now);
		blend_px_t       px;
		hsv_t            bg;
		longint unsigned lt, lidx, lspan, lspeed, lslope, n, pos, lag, alpha;
		px.idx = idx;
		if (span_ticks_sh == '0) begin
			px.col = fill_sh;
			return px;
		end
		lt     = t_now;
		lidx   = idx;
		lspan  = span_ticks_sh;
		lspeed = sweep_speed_sh;
		lslope = edge_slope_sh;
		if (edge_slope_sh == '0) begin
			alpha = (lt << 16) / lspan;
		end else begin
			// clamp the strip length into the usable range
			n = strip_len_sh;
			if (n < 2) n = 2;
			if (n > PIXELS) n = PIXELS;
			pos = (lidx << 16) / (n - 1);
			lag = ((lt * lspeed) << 8) / lspan;
			alpha = (pos >= lag) ? 0 : (((lag - pos) * lslope) >> 8);
		end
		if (alpha > 65536) alpha = 65536;
		bg = bg_shadow[idx];
		px.col.h = mix_channel(bg.h, fill_sh.h, alpha);
		px.col.s = mix_channel(bg.s, fill_sh.s, alpha);
		px.col.v = mix_channel(bg.v, fill_sh.v, alpha);
		return px;
	endfunction

	// Offer one beat; valid stays high into the next beat when there is no gap
	task automatic send_pixel(pixel_act_t act, logic [IDX_W-1:0] idx, logic [COL_W-1:0] h,
			logic [COL_W-1:0] s, logic [COL_W-1:0] v, logic [TIME_W-1:0] t_now);
		int gap;
		gap = src_idle_on ? $urandom_range(0, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= TDATA_IN_W'({t_now, v, s, h, idx});
		do @(posedge clk); while (!s_axis_tready);
		// beat accepted: update the shadow store or queue the expected colour
		if (act == PX_CAPTURE) begin
			bg_shadow[idx] = '{h: h, s: s, v: v};
			if (!bg_written[idx]) begin
				bg_written[idx] = 1'b1;
				captured_idx.push_back(idx);
			end
		end else begin
			blended_q.push_back(blend_pixel(idx, t_now));
		end
	endtask

	task automatic capture(int unsigned idx, int unsigned h, int unsigned s, int unsigned v);
		send_pixel(PX_CAPTURE, idx, h, s, v, $urandom_range(0, 65535));
	endtask

	task automatic render(int unsigned idx, int unsigned t_now);
		send_pixel(PX_RENDER, idx, $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255), t_now);
	endtask

	// Drop valid, drain expected beats, then allow for trailing captures
	task automatic settle();
		int waited;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (blended_q.size() != 0 && waited < DRAIN_CAP) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (r)
			CFG_FILL_HUE:     fill_sh.h      = val[COL_W-1:0];
			CFG_FILL_SAT:     fill_sh.s      = val[COL_W-1:0];
			CFG_FILL_VAL:     fill_sh.v      = val[COL_W-1:0];
			CFG_EDGE_SLOPE:   edge_slope_sh  = val;
			CFG_SWEEP_SPEED:  sweep_speed_sh = val;
			CFG_SPAN_TICKS:   span_ticks_sh  = val;
			CFG_STRIP_LENGTH: strip_len_sh   = val[LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(logic [COL_W-1:0] fh, logic [COL_W-1:0] fs,
			logic [COL_W-1:0] fv, logic [CFG_W-1:0] slope, logic [CFG_W-1:0] speed,
			logic [CFG_W-1:0] span, logic [LEN_W-1:0] len);
		write_reg(CFG_FILL_HUE, fh);
		write_reg(CFG_FILL_SAT, fs);
		write_reg(CFG_FILL_VAL, fv);
		write_reg(CFG_EDGE_SLOPE, slope);
		write_reg(CFG_SWEEP_SPEED, speed);
		write_reg(CFG_SPAN_TICKS, span);
		write_reg(CFG_STRIP_LENGTH, len);
	endtask

	// Zero span: every render is the fill colour, captures still land
	task automatic test_instant_fill();
		capture(0, 8'h00, 8'h00, 8'h00);
		capture(1023, 8'hFF, 8'hFF, 8'hFF);
		capture(1, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
		capture(511, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
		render(0, 16'h0000);
		render(1023, 16'hFFFF);
		settle();
		write_reg(CFG_FILL_HUE, 16'h00FF);
		write_reg(CFG_FILL_SAT, 16'h0080);
		write_reg(CFG_FILL_VAL, 16'h0001);
		render(1023, 16'h0000);
		render(0, 16'hFFFF);
		settle();
	endtask

	// Uniform crossfade from start through past the end of the span
	task automatic test_crossfade();
		apply_setting(8'd200, 8'd17, 8'hFF, 16'h0000, SPEED_UNITY, 16'd1000, 11'd1024);
		render(0, 0);
		render(1023, 500);
		render(0, 1000);
		render(1023, 16'hFFFF);
		settle();
	endtask

	// Wipe edge: index past the strip, time past the span, odd strip lengths
	task automatic test_wipe_edges();
		apply_setting(8'h10, 8'hE0, 8'h7F, 16'h0100, SPEED_UNITY, 16'd100, 11'd2);
		render(0, 0);
		render(1, 50);
		render(1023, 100);
		render(1, 16'hFFFF);
		render(511, 150);
		settle();
		write_reg(CFG_STRIP_LENGTH, 16'd0);
		render(511, 60);
		settle();
		write_reg(CFG_STRIP_LENGTH, 16'd1);
		render(511, 60);
		settle();
		write_reg(CFG_STRIP_LENGTH, 16'd2047);
		render(511, 60);
		settle();
	endtask

	// Random settings, each followed by a burst of captures and renders
	task automatic test_random_phases();
		logic [CFG_W-1:0] span, slope, speed;
		logic [LEN_W-1:0] len;
		logic [COL_W-1:0] fh, fs, fv;
		int unsigned      n_len, mode, idx, t_hi;
		longint unsigned  reach;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph == 0) begin
				span = 16'hFFFF; slope = 16'hFFFF; speed = 16'hFFFF; len = 11'h7FF;
				fh = 8'hFF; fs = 8'hFF; fv = 8'hFF;
			end else if (ph == 1) begin
				span = 16'd1; slope = 16'd1; speed = 16'd0; len = 11'd0;
				fh = 8'h00; fs = 8'h00; fv = 8'h00;
			end else begin
				case ($urandom_range(0, 5))
					0:       span = 16'd0;
					1:       span = 16'd1;
					2:       span = $urandom_range(0, 65535);
					default: span = $urandom_range(2, 2000);
				endcase
				case ($urandom_range(0, 5))
					0, 1:    slope = 16'd0;
					2:       slope = $urandom_range(0, 65535);
					default: slope = $urandom_range(1, 4096);
				endcase
				case ($urandom_range(0, 4))
					0:       speed = 16'd0;
					1:       speed = $urandom_range(0, 65535);
					default: speed = $urandom_range(64, 1024);
				endcase
				case ($urandom_range(0, 7))
					0:       len = 11'd0;
					1:       len = 11'd1;
					2:       len = 11'd2;
					3:       len = 11'd1024;
					4:       len = $urandom_range(1025, 2047);
					default: len = $urandom_range(3, 1023);
				endcase
				fh = $urandom_range(0, 255);
				fs = $urandom_range(0, 255);
				fv = $urandom_range(0, 255);
			end
			apply_setting(fh, fs, fv, slope, speed, span, len);
			mode = (ph == 0) ? 0 : $urandom_range(0, 3);
			src_idle_on  = (mode & 1) != 0;
			sink_idle_on = (mode & 2) != 0;

			n_len = (len < 2) ? 2 : ((len > PIXELS) ? PIXELS : len);
			// time range over which the blend is still changing
			if (slope == '0)
				reach = 2 * longint'(span);
			else
				reach = (longint'(span) * 512) / ((speed == '0) ? 1 : speed) + 1;
			t_hi = (reach > 65535) ? 65535 : reach;

			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if ($urandom_range(0, 9) < 3) begin
					idx = ($urandom_range(0, 9) < 6) ? $urandom_range(0, n_len - 1)
						: $urandom_range(0, PIXELS - 1);
					capture(idx, $urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255));
				end else begin
					render(captured_idx[$urandom_range(0, captured_idx.size() - 1)],
						$urandom_range(0, 1) ? $urandom_range(0, 65535)
						: $urandom_range(0, t_hi));
				end
			end
			settle();
		end
	endtask

	// Hold the output off while the input keeps offering, then pause and resume
	task automatic test_backpressure();
		apply_setting($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
			16'h0000, SPEED_UNITY, 16'd300, 11'd64);
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		@(posedge clk);
		sink_hold = LONG_HOLD;
		for (int k = 0; k < 60; k++)
			render(captured_idx[$urandom_range(0, captured_idx.size() - 1)],
				$urandom_range(0, 400));
		settle();
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		for (int k = 0; k < 20; k++) begin
			if ($urandom_range(0, 2) == 0)
				capture($urandom_range(0, 63), $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255));
			else
				render(captured_idx[$urandom_range(0, captured_idx.size() - 1)],
					$urandom_range(0, 400));
		end
		settle();
	endtask

	// Output ready: long hold first, then per-beat gaps
	initial begin : sink_drive
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				m_axis_tready <= 1'b0;
				sink_hold--;
			end else if (sink_gap > 0) begin
				m_axis_tready <= 1'b0;
				sink_gap--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Compare every output beat with the oldest expected pixel
	always @(posedge clk) begin : result_check
		blend_px_t want, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sink_gap = sink_idle_on ? $urandom_range(0, 3) : 0;
			got.idx   = m_axis_tdata[9:0];
			got.col.h = m_axis_tdata[17:10];
			got.col.s = m_axis_tdata[25:18];
			got.col.v = m_axis_tdata[33:26];
			if (blended_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected beat idx=%0d h=%02h s=%02h v=%02h", $realtime,
						got.idx, got.col.h, got.col.s, got.col.v);
			end else begin
				want = blended_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch exp idx=%0d h=%02h s=%02h v=%02h, got idx=%0d h=%02h s=%02h v=%02h",
							$realtime, want.idx, want.col.h, want.col.s, want.col.v,
							got.idx, got.col.h, got.col.s, got.col.v);
				end
			end
		end
	end

	initial begin : run
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_FILL_HUE;
		cfg_data      = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_instant_fill();
		test_crossfade();
		test_wipe_edges();
		test_random_phases();
		test_backpressure();

		if (mismatches == 0 && blended_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Hard stop well beyond the slowest correct run
	initial begin : watchdog
		#(2_000_000);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lfwb_pkg.sv
rtl/lfwb_ram.sv
rtl/lfwb_quot_pipe.sv
rtl/led_fill_wipe_blend.sv
rtl/lfwb_checker.sv
tb/sv/led_fill_wipe_blend_tb.sv
